// File: hw/rtl/pft_pkg.sv
// Shared types and constants of the page frame table.
package pft_pkg;

  // Default sizes of the frame store
  localparam int unsigned NumFramesDef = 128;
  localparam int unsigned PidBitsDef   = 8;
  localparam int unsigned PageBitsDef  = 10;

  // Fixed field widths of the request and response channels
  localparam int unsigned ProcIdW  = 8;
  localparam int unsigned PageNumW = 10;
  localparam int unsigned NeedW    = 8;
  localparam int unsigned OpW      = 2;
  localparam int unsigned FrameIdxW = 7;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_CHECK  = 2'd3
  } pft_op_e;

  // Control part of the token that walks the cell chain
  typedef struct packed {
    logic    active;
    pft_op_e op;
    logic    hit;
  } pft_token_t;

endpackage

// File: hw/rtl/pft_req_if.sv
// Request channel of the page frame table.
interface pft_req_if;
  logic                           valid;
  logic                           ready;
  logic [pft_pkg::OpW-1:0]        op;
  logic [pft_pkg::ProcIdW-1:0]    proc_id;
  logic [pft_pkg::PageNumW-1:0]   page_number;
  logic [pft_pkg::NeedW-1:0]      frames_needed;

  modport source (output valid, op, proc_id, page_number, frames_needed, input ready);
  modport sink   (input valid, op, proc_id, page_number, frames_needed, output ready);
endinterface

// File: hw/rtl/pft_rsp_if.sv
// Response channel of the page frame table.
interface pft_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [pft_pkg::FrameIdxW-1:0]   frame_index;
  logic                            enough_free;

  modport source (output valid, found, frame_index, enough_free, input ready);
  modport sink   (input valid, found, frame_index, enough_free, output ready);
endinterface

// File: hw/rtl/page_frame_table_top.sv
// Top level of the page frame table: request control and the chain of frame cells.
//
// Each of the NUM_FRAMES frames lives in a cell of a linear chain. An accepted
// request launches a token that walks the chain one cell per clock unless a
// waiting response stalls it; each cell matches, claims, clears or counts its own
// frame as the token passes, and the token carries the hit flag, the first
// matching index and the free count. A request passes from the launch register
// through the registers of the NUM_FRAMES cells into the response register.
// One request is in flight at a time; the next is accepted the cycle after the
// previous result is registered, even while that result still waits to be
// taken. A stalled response stalls the whole chain until it drains. Frames
// whose entry was never written are never read, as only valid frames match.
module page_frame_table_top #(
  parameter int unsigned NUM_FRAMES = pft_pkg::NumFramesDef,
  parameter int unsigned PID_BITS   = pft_pkg::PidBitsDef,
  parameter int unsigned PAGE_BITS  = pft_pkg::PageBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pft_req_if.sink    req_i,
  pft_rsp_if.source  rsp_o
);

  localparam int unsigned IdxW = $clog2(NUM_FRAMES);
  localparam int unsigned CntW = $clog2(NUM_FRAMES + 1);

  // Request handshake and held request fields
  logic                            busy_q;
  logic                            req_fire;
  logic                            en;
  pft_pkg::pft_token_t             launch_q;
  logic [PID_BITS-1:0]             pid_q;
  logic [PAGE_BITS-1:0]            page_q;
  logic [pft_pkg::NeedW-1:0]       need_q;

  // Chain links: link 0 is the launch register, link NUM_FRAMES the chain tail
  pft_pkg::pft_token_t             tok [NUM_FRAMES+1];
  logic [IdxW-1:0]                 idx [NUM_FRAMES+1];
  logic [CntW-1:0]                 cnt [NUM_FRAMES+1];
  logic [NUM_FRAMES:0]             tok_active;

  // Response register
  logic                            rsp_valid_q;
  logic                            rsp_found_q;
  logic [pft_pkg::FrameIdxW-1:0]   rsp_index_q;
  logic                            rsp_enough_q;
  logic                            tail_done;

  assign req_i.ready = !busy_q;
  assign req_fire    = req_i.valid && !busy_q;

  // Hold the whole chain while a finished response is still waiting
  assign en = !(rsp_valid_q && !rsp_o.ready);

  assign tail_done = en && tok[NUM_FRAMES].active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      launch_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        busy_q <= 1'b1;
      end else if (tail_done) begin
        busy_q <= 1'b0;
      end
      // launch for one advancing cycle
      if (req_fire) begin
        launch_q.active <= 1'b1;
        launch_q.op     <= pft_pkg::pft_op_e'(req_i.op);
        launch_q.hit    <= 1'b0;
      end else if (en) begin
        launch_q.active <= 1'b0;
      end
      if (tail_done) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      pid_q        <= PID_BITS'({{32{1'b0}}, req_i.proc_id});
      page_q       <= PAGE_BITS'({{32{1'b0}}, req_i.page_number});
      need_q       <= req_i.frames_needed;
    end
    if (tail_done) begin
      rsp_found_q  <= tok[NUM_FRAMES].hit;
      rsp_index_q  <= tok[NUM_FRAMES].hit
                      ? pft_pkg::FrameIdxW'({{pft_pkg::FrameIdxW{1'b0}}, idx[NUM_FRAMES]})
                      : '0;
      // zero needed frames passes trivially, since the count is never negative
      rsp_enough_q <= (tok[NUM_FRAMES].op == pft_pkg::OP_CHECK)
                      && (32'(cnt[NUM_FRAMES]) >= 32'(need_q));
    end
  end

  // Head of the chain: fresh accumulators
  assign tok[0] = launch_q;
  assign idx[0] = '0;
  assign cnt[0] = '0;

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    pft_cell #(
      .PID_BITS  (PID_BITS),
      .PAGE_BITS (PAGE_BITS),
      .IDX_W     (IdxW),
      .CNT_W     (CntW),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .pid_i  (pid_q),
      .page_i (page_q),
      .tok_i  (tok[g]),
      .idx_i  (idx[g]),
      .cnt_i  (cnt[g]),
      .tok_o  (tok[g+1]),
      .idx_o  (idx[g+1]),
      .cnt_o  (cnt[g+1])
    );
  end

  for (genvar g = 0; g <= NUM_FRAMES; g++) begin : g_active
    assign tok_active[g] = tok[g].active;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.found       = rsp_found_q;
  assign rsp_o.frame_index = rsp_index_q;
  assign rsp_o.enough_free = rsp_enough_q;

`ifndef SYNTHESIS
  // At most one token walks the chain
  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_active))
    else $error("more than one request token in the frame chain");

  // A new request only enters an empty chain
  a_accept_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |-> (tok_active == '0))
    else $error("request accepted while a token is in flight");

  // A token leaving the chain always lands in the response register
  a_tail_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_done |=> (rsp_valid_q && !busy_q))
    else $error("finished token not captured as a response");

  // Busy whenever a token is launched or walking
  a_busy_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_active != '0) |-> busy_q)
    else $error("token in chain while control is idle");
`endif

endmodule

// File: hw/rtl/pft_cell.sv
// One frame of the table: holds its entry and passes the request token on.
module pft_cell #(
  parameter int unsigned PID_BITS  = pft_pkg::PidBitsDef,
  parameter int unsigned PAGE_BITS = pft_pkg::PageBitsDef,
  parameter int unsigned IDX_W     = 7,
  parameter int unsigned CNT_W     = 8,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [PID_BITS-1:0]  pid_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  pft_pkg::pft_token_t  tok_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  logic [CNT_W-1:0]     cnt_i,
  output pft_pkg::pft_token_t  tok_o,
  output logic [IDX_W-1:0]     idx_o,
  output logic [CNT_W-1:0]     cnt_o
);

  logic                 valid_q, valid_d;
  logic [PID_BITS-1:0]  owner_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 write_en;
  pft_pkg::pft_token_t  tok_q, tok_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  always_comb begin
    valid_d  = valid_q;
    write_en = 1'b0;
    tok_d    = tok_i;
    idx_d    = idx_i;
    cnt_d    = cnt_i;
    if (tok_i.active) begin
      unique case (tok_i.op)
        pft_pkg::OP_LOOKUP: begin
          if (!tok_i.hit && valid_q && owner_q == pid_i && page_q == page_i) begin
            tok_d.hit = 1'b1;
            idx_d     = IDX_W'(CELL_IDX);
          end
        end
        pft_pkg::OP_ALLOC: begin
          // claim only the first free frame on the way
          if (!tok_i.hit && !valid_q) begin
            valid_d   = 1'b1;
            write_en  = 1'b1;
            tok_d.hit = 1'b1;
            idx_d     = IDX_W'(CELL_IDX);
          end
        end
        pft_pkg::OP_FREE: begin
          if (valid_q && owner_q == pid_i) begin
            valid_d   = 1'b0;
            tok_d.hit = 1'b1;
          end
        end
        pft_pkg::OP_CHECK: begin
          if (!valid_q) begin
            cnt_d = cnt_i + CNT_W'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      if (write_en) begin
        owner_q <= pid_i;
        page_q  <= page_i;
      end
    end
  end

  assign tok_o = tok_q;
  assign idx_o = idx_q;
  assign cnt_o = cnt_q;

endmodule
